// ===== hdl/string_hash_bucket_index_core_defines.svh =====
// ----------------------------------------------------------------------------
// string_hash_bucket_index_core_defines
// Assertion macros shared by the bucket index core modules.
// ----------------------------------------------------------------------------
`ifndef STRING_HASH_BUCKET_INDEX_CORE_DEFINES_SVH
`define STRING_HASH_BUCKET_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SHBI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shbi assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SHBI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shbi assertion failed");

`endif

// ===== hdl/shbi_pkg.sv =====
// ----------------------------------------------------------------------------
// shbi_pkg
// Widths, register indexes, sequencer states and interface structs of the
// string hash bucket index core.
// ----------------------------------------------------------------------------
package shbi_pkg;

	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int CFG_IDX_W = 8;
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE     = CFG_IDX_W'(1);

	localparam logic [WORD_W-1:0] BUCKET_COUNT_RST = WORD_W'(1);
	localparam logic              KEY_MODE_INT     = 1'b0;
	localparam logic              KEY_MODE_STR     = 1'b1;
	localparam logic [BYTE_W-1:0] STR_TERMINATOR   = '0;
	localparam int                HASH_SHIFT       = 5;  // 31*h = (h << 5) - h

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_HOLD   = 3'b100
	} seq_state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== hdl/shbi_mod_unit.sv =====
// ----------------------------------------------------------------------------
// shbi_mod_unit
// Restoring remainder unit: one trial subtraction per cycle over the bits of
// the dividend. A zero divisor leaves the dividend itself as the remainder.
// ----------------------------------------------------------------------------
`include "string_hash_bucket_index_core_defines.svh"

module shbi_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  shbi_pkg::div_ctrl_t ctrl,
	input  shbi_pkg::word_t   dividend,
	input  shbi_pkg::word_t   divisor,
	output shbi_pkg::div_stat_t stat,
	output shbi_pkg::word_t   remainder
);
	import shbi_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	word_t                dvd_q;
	word_t                dvs_q;
	word_t                rem_q;

	logic [WORD_W:0] shifted;
	logic [WORD_W:0] trial;
	logic            last_step;

	assign shifted   = {rem_q, dvd_q[WORD_W-1]};
	assign trial     = shifted - {1'b0, dvs_q};
	assign last_step = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			// A borrow out of the trial means the divisor did not fit.
			if (trial[WORD_W]) begin
				rem_q <= shifted[WORD_W-1:0];
			end else begin
				rem_q <= trial[WORD_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

	`SHBI_ASSERT_NOW(a_no_restart, ctrl.start, !busy_q)
	`SHBI_ASSERT_NEXT(a_start_busy, ctrl.start, busy_q && (cnt_q == '0))
	`SHBI_ASSERT_NEXT(a_last_done, last_step, done_q && !busy_q)

endmodule

// ===== hdl/string_hash_bucket_index_core.sv =====
// ----------------------------------------------------------------------------
// string_hash_bucket_index_core
// Hash-table bucket selector for integer keys and zero-terminated byte
// strings, with a shared iterative remainder unit.
// ----------------------------------------------------------------------------
// A non-zero string byte is folded into the running hash in the cycle it is
// accepted, so string bytes stream in at one per cycle with no result. An
// integer key or a string terminator starts the remainder unit, which works
// one quotient bit per cycle; in_ready is low until the result sits in the
// output register, so the block takes no new key while a result is pending.
// The output register decouples the result side: the block takes new bytes
// while a bucket index still waits for out_ready. Writing a bucket count of
// zero returns the unreduced key or hash.
`include "string_hash_bucket_index_core_defines.svh"

module string_hash_bucket_index_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [shbi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [shbi_pkg::WORD_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [shbi_pkg::WORD_W-1:0]         key_value,
	input  logic [shbi_pkg::BYTE_W-1:0]         key_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [shbi_pkg::WORD_W-1:0]         bucket_index
);
	import shbi_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;
	word_t      bucket_count_q;
	logic       key_mode_q;
	word_t      hash_q;
	logic       out_valid_q;
	word_t      bucket_q;

	div_ctrl_t  div_ctrl;
	div_stat_t  div_stat;
	word_t      div_dividend;
	word_t      div_rem;

	logic in_acc;
	logic byte_acc;
	logic out_free;
	logic load_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign byte_acc  = in_acc && (key_mode_q == KEY_MODE_STR) && (key_byte != STR_TERMINATOR);
	assign out_free  = !out_valid_q || out_ready;

	assign div_ctrl.start = in_acc && !byte_acc;
	assign div_dividend   = (key_mode_q == KEY_MODE_INT) ? key_value : hash_q;

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (div_ctrl.start) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_stat.done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				// The remainder unit keeps its result until the next start.
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bucket_count_q <= BUCKET_COUNT_RST;
			key_mode_q     <= KEY_MODE_STR;
			hash_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BUCKET_COUNT) begin
					bucket_count_q <= cfg_data;
				end else if (cfg_index == REG_KEY_MODE) begin
					key_mode_q <= cfg_data[0];
				end
			end
			if (byte_acc) begin
				hash_q <= (hash_q << HASH_SHIFT) - hash_q + WORD_W'(key_byte);
			end else if (div_ctrl.start && (key_mode_q == KEY_MODE_STR)) begin
				hash_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bucket_q <= div_rem;
		end
	end

	shbi_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (div_dividend),
		.divisor   (bucket_count_q),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

	`SHBI_ASSERT_NOW(a_done_in_divide, div_stat.done, state_q == ST_DIVIDE)
	`SHBI_ASSERT_NOW(a_hold_has_out, state_q == ST_HOLD, out_valid_q)
	`SHBI_ASSERT_NEXT(a_byte_stays_idle, byte_acc, state_q == ST_IDLE && !div_stat.busy)
	`SHBI_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q)

endmodule
